[hdl/lxfc_pkg.sv]
// Shared constants and status codes for the length/XOR frame checker.
`default_nettype none

package lxfc_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned StatW  = 2;

    typedef logic [ByteW-1:0] byte_t;
    typedef logic [StatW-1:0] status_t;

    localparam byte_t MarkerByte  = 8'h00;
    localparam byte_t MinFrameLen = 8'd3;
    localparam byte_t MaxLenReset = 8'd255;

    localparam status_t StOk        = 2'd0;
    localparam status_t StBadLen    = 2'd1;
    localparam status_t StBadMarker = 2'd2;
    localparam status_t StBadSum    = 2'd3;

    localparam logic KindPayload = 1'b0;
    localparam logic KindStatus  = 1'b1;

endpackage

`default_nettype wire

[hdl/length_xor_frame_checker.sv]
// Length-prefixed frame checker with XOR checksum, top level.
`default_nettype none

// Takes one received byte per item and checks frames laid out as: length byte
// (counting the whole frame), a 0x00 marker byte, length-3 payload bytes, then
// a checksum byte equal to the XOR of every earlier frame byte, length byte
// included. Each payload byte comes out as an item with out_kind 0 and its
// running count; the checksum byte produces a status item (out_kind 1) giving
// ok, bad marker or bad checksum, bad marker taking precedence. A length byte
// below 3 or above max_frame_len produces a bad-length status at once and the
// checker keeps waiting for a length byte. Length and marker bytes that are
// accepted produce no item. One byte is accepted per cycle while no result
// waits untaken: the phase, counter and running XOR update in a single pass
// and the result lands in the output register, which frees as it is taken, so
// a byte may be accepted in the same cycle a waiting result leaves. Write
// max_frame_len (reset 255) only while the checker is idle.
module length_xor_frame_checker
    import lxfc_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    // configuration
    input  wire logic          cfg_wr_en,
    input  wire byte_t         cfg_wr_data,
    // received bytes
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire byte_t         s_rx_byte,
    // results
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic               m_out_kind,
    output byte_t              m_out_byte,
    output status_t            m_frame_status,
    output byte_t              m_payload_count
);

    typedef enum logic [1:0] {
        PH_WAIT   = 2'd0,
        PH_MARKER = 2'd1,
        PH_BODY   = 2'd2
    } phase_t;

    phase_t  phase_reg,      phase_next;
    byte_t   remaining_reg,  remaining_next;
    byte_t   xor_reg,        xor_next;
    logic    marker_bad_reg, marker_bad_next;
    byte_t   seen_reg,       seen_next;
    byte_t   max_len_reg;

    logic    m_valid_reg,    m_valid_next;
    logic    kind_reg,       kind_next;
    byte_t   obyte_reg,      obyte_next;
    status_t status_reg,     status_next;
    byte_t   count_reg,      count_next;

    logic    accept;
    logic    emit;

    // Output register frees as its result is taken.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        phase_next      = phase_reg;
        remaining_next  = remaining_reg;
        xor_next        = xor_reg;
        marker_bad_next = marker_bad_reg;
        seen_next       = seen_reg;
        emit            = 1'b0;
        kind_next       = KindPayload;
        obyte_next      = '0;
        status_next     = StOk;
        count_next      = '0;

        unique case (phase_reg)
            PH_MARKER: begin
                // Record a bad marker but keep consuming the frame.
                marker_bad_next = (s_rx_byte != MarkerByte);
                xor_next        = xor_reg ^ s_rx_byte;
                remaining_next  = remaining_reg - 8'd1;
                phase_next      = PH_BODY;
            end
            PH_BODY: begin
                if (remaining_reg > 8'd1) begin
                    // Payload byte: pass it on with its running count.
                    xor_next       = xor_reg ^ s_rx_byte;
                    remaining_next = remaining_reg - 8'd1;
                    seen_next      = seen_reg + 8'd1;
                    emit           = 1'b1;
                    obyte_next     = s_rx_byte;
                    count_next     = seen_reg + 8'd1;
                end else begin
                    // Checksum byte: report the frame and go back to waiting.
                    emit        = 1'b1;
                    kind_next   = KindStatus;
                    count_next  = seen_reg;
                    if (marker_bad_reg) begin
                        status_next = StBadMarker;
                    end else if (xor_reg != s_rx_byte) begin
                        status_next = StBadSum;
                    end else begin
                        status_next = StOk;
                    end
                    phase_next     = PH_WAIT;
                    remaining_next = '0;
                end
            end
            default: begin
                // Waiting for a length byte; the unused code acts the same.
                if (s_rx_byte < MinFrameLen || s_rx_byte > max_len_reg) begin
                    phase_next      = PH_WAIT;
                    remaining_next  = '0;
                    xor_next        = '0;
                    marker_bad_next = 1'b0;
                    seen_next       = '0;
                    emit            = 1'b1;
                    kind_next       = KindStatus;
                    status_next     = StBadLen;
                end else begin
                    xor_next        = s_rx_byte;
                    remaining_next  = s_rx_byte - 8'd1;
                    marker_bad_next = 1'b0;
                    seen_next       = '0;
                    phase_next      = PH_MARKER;
                end
            end
        endcase
    end

    // Hold the result until taken; load a new one when an accepted byte emits.
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (accept && emit) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_WAIT;
            remaining_reg  <= '0;
            xor_reg        <= '0;
            marker_bad_reg <= 1'b0;
            seen_reg       <= '0;
            max_len_reg    <= MaxLenReset;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                max_len_reg <= cfg_wr_data;
            end
            if (accept) begin
                phase_reg      <= phase_next;
                remaining_reg  <= remaining_next;
                xor_reg        <= xor_next;
                marker_bad_reg <= marker_bad_next;
                seen_reg       <= seen_next;
            end
            m_valid_reg <= m_valid_next;
        end
        // Result payload needs no reset.
        if (accept && emit) begin
            kind_reg   <= kind_next;
            obyte_reg  <= obyte_next;
            status_reg <= status_next;
            count_reg  <= count_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_kind      = kind_reg;
    assign m_out_byte      = obyte_reg;
    assign m_frame_status  = status_reg;
    assign m_payload_count = count_reg;

endmodule

`default_nettype wire
